/* rtl/core/delimited_field_remover_top_defines.svh */
`ifndef DELIMITED_FIELD_REMOVER_TOP_DEFINES_SVH
`define DELIMITED_FIELD_REMOVER_TOP_DEFINES_SVH

// Same-cycle check, off while reset is high.
`define DFR_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle check, off while reset is high.
`define DFR_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// Next-cycle check that also covers reset itself.
`define DFR_ASSERT_ALWAYS(label, clk, ante, cons, msg) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/core/dfr_pkg.sv */
package dfr_pkg;

   localparam int KEY_MAX   = 32;
   localparam int SEP_MAX   = 4;
   localparam int KEY_WORDS = 4;
   localparam int WORD_W    = 64;
   localparam int POS_W     = 6;
   localparam int SEP_LEN_W = 3;
   localparam int CSR_IDX_W = 3;

   localparam logic [7:0] SEP_DEFAULT = 8'h2C;

   localparam logic [CSR_IDX_W-1:0] CSR_KEY_WORD_0 = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_KEY_WORD_1 = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_KEY_WORD_2 = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_KEY_WORD_3 = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_KEY_LENGTH = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_SEP_BYTES  = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_SEP_LENGTH = 3'd6;

   typedef enum logic [1:0] {
      EV_BYTE,
      EV_FIELD_END,
      EV_LIST_END
   } ev_kind_type;

   typedef struct packed {
      ev_kind_type kind;
      logic [7:0]  data;
      logic        step_last;
   } event_type;

   typedef struct packed {
      logic [7:0] data;
      logic       valid;
      logic       last;
   } rsp_item_type;

   // Effective settings: lengths already clamped, zero separator length mapped to comma.
   typedef struct packed {
      logic [KEY_MAX*8-1:0]   key;
      logic [POS_W-1:0]       key_len;
      logic [SEP_MAX*8-1:0]   sep;
      logic [SEP_LEN_W-1:0]   sep_len;
   } cfg_type;

endpackage

/* rtl/core/dfr_fifo.sv */
module dfr_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wdata,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] rdata,
   output logic             empty
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [AW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == CW'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rdata   = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      count_in = count_ff + CW'(do_push) - CW'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wdata;
      end
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

/* rtl/core/dfr_front.sv */
module dfr_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  logic [7:0]          in_byte,
   input  logic                in_valid,
   input  logic                in_last,
   output logic                full,
   input  dfr_pkg::cfg_type    cfg,
   output logic                evt_push,
   output dfr_pkg::event_type  evt_data,
   input  logic                evt_full
);

   import dfr_pkg::*;

   localparam int LEN_W = $clog2(SEP_MAX + 1);
   localparam int IDX_W = $clog2(SEP_MAX);

   typedef enum logic [1:0] {
      F_IDLE,
      F_SCAN,
      F_FLUSH
   } front_state_type;

   front_state_type             state_ff, state_in, done_state;
   logic [SEP_MAX-1:0][7:0]     hold_ff, hold_in, shifted;
   logic [LEN_W-1:0]            len_ff, len_in;
   logic                        last_ff, last_in;
   logic [SEP_MAX-1:0]          byte_ok;
   logic                        accept, match_all, full_match, part_match;

   assign full       = (state_ff != F_IDLE);
   assign accept     = push && !full;
   assign done_state = last_ff ? F_FLUSH : F_IDLE;

   // hold_ff[0 .. len-1] is the window of bytes that may still open a delimiter
   always_comb begin
      for (int i = 0; i < SEP_MAX; i++) begin
         byte_ok[i] = (LEN_W'(i) >= len_ff) || (SEP_LEN_W'(i) >= cfg.sep_len)
                      || (hold_ff[i] == cfg.sep[i*8 +: 8]);
         shifted[i] = (i < SEP_MAX - 1) ? hold_ff[(i + 1) % SEP_MAX] : 8'h00;
      end
   end

   assign match_all  = &byte_ok;
   assign full_match = match_all && (SEP_LEN_W'(len_ff) == cfg.sep_len);
   assign part_match = match_all && (SEP_LEN_W'(len_ff) < cfg.sep_len);

   always_comb begin
      state_in = state_ff;
      hold_in  = hold_ff;
      len_in   = len_ff;
      last_in  = last_ff;
      evt_push = 1'b0;
      evt_data = '{kind: EV_BYTE, data: hold_ff[0], step_last: last_ff};
      unique case (state_ff)
         F_IDLE: begin
            if (accept) begin
               last_in = in_last;
               if (in_valid) begin
                  hold_in[len_ff[IDX_W-1:0]] = in_byte;
                  len_in   = len_ff + 1'b1;
                  state_in = F_SCAN;
               end else if (in_last) begin
                  state_in = F_FLUSH;
               end
            end
         end
         F_SCAN: begin
            if (len_ff == '0 || part_match) begin
               state_in = done_state;
            end else if (!evt_full) begin
               evt_push = 1'b1;
               if (full_match) begin
                  evt_data.kind = EV_FIELD_END;
                  len_in        = '0;
                  state_in      = done_state;
               end else begin
                  hold_in = shifted;
                  len_in  = len_ff - 1'b1;
                  if (len_ff == LEN_W'(1)) begin
                     state_in = done_state;
                  end
               end
            end
         end
         F_FLUSH: begin
            if (!evt_full) begin
               evt_push = 1'b1;
               if (len_ff != '0) begin
                  hold_in = shifted;
                  len_in  = len_ff - 1'b1;
               end else begin
                  evt_data.kind = EV_LIST_END;
                  state_in      = F_IDLE;
               end
            end
         end
         default: begin
            state_in = F_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      hold_ff <= hold_in;
      if (reset) begin
         state_ff <= F_IDLE;
         len_ff   <= '0;
         last_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         len_ff   <= len_in;
         last_ff  <= last_in;
      end
   end

endmodule

/* rtl/core/dfr_back.sv */
module dfr_back (
   input  logic                  clock,
   input  logic                  reset,
   input  dfr_pkg::cfg_type      cfg,
   input  logic                  evt_empty,
   input  dfr_pkg::event_type    evt_head,
   output logic                  evt_pop,
   input  logic                  out_full,
   output logic                  out_push,
   output dfr_pkg::rsp_item_type out_data
);

   import dfr_pkg::*;

   localparam int CNT_W  = $clog2(KEY_MAX);
   localparam int SIDX_W = $clog2(SEP_MAX);
   localparam logic [7:0] BYTE_NUL = 8'h00;

   typedef enum logic [1:0] {
      B_IDLE,
      B_SEP,
      B_KEY,
      B_TAIL
   } back_state_type;

   back_state_type    state_ff, state_in, open_state;
   event_type         cur_ff, cur_in, ev;
   logic [POS_W-1:0]  pos_ff, pos_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              match_ff, match_in;
   logic              any_ff, any_in;
   logic              staged_valid_ff, staged_valid_in;
   logic [7:0]        staged_ff, staged_in;
   logic              go, hit, open_now, emit, finish;
   logic [7:0]        emit_byte, key_at_pos, key_at_cnt, sep_at_cnt;

   assign go         = !out_full;
   assign ev         = (state_ff == B_IDLE) ? evt_head : cur_ff;
   assign key_at_pos = cfg.key[{pos_ff[CNT_W-1:0], 3'b000} +: 8];
   assign key_at_cnt = cfg.key[{cnt_ff, 3'b000} +: 8];
   assign sep_at_cnt = cfg.sep[{cnt_ff[SIDX_W-1:0], 3'b000} +: 8];
   assign hit        = match_ff && (pos_ff < cfg.key_len) && (key_at_pos == evt_head.data);
   assign open_state = any_ff ? B_SEP : ((pos_ff == '0) ? B_TAIL : B_KEY);

   // field sequencer: a held key prefix is replayed as separator (once a field was kept), key bytes, then the tail
   always_comb begin
      state_in  = state_ff;
      cur_in    = cur_ff;
      pos_in    = pos_ff;
      cnt_in    = cnt_ff;
      match_in  = match_ff;
      any_in    = any_ff;
      evt_pop   = 1'b0;
      open_now  = 1'b0;
      emit      = 1'b0;
      emit_byte = ev.data;
      finish    = 1'b0;
      unique case (state_ff)
         B_IDLE: begin
            if (go && !evt_empty) begin
               evt_pop = 1'b1;
               cur_in  = evt_head;
               if (evt_head.kind == EV_BYTE) begin
                  if (hit) begin
                     pos_in = pos_ff + 1'b1;
                  end else if (match_ff) begin
                     open_now = 1'b1;
                  end else begin
                     emit = 1'b1;
                  end
               end else if (match_ff && pos_ff != cfg.key_len) begin
                  open_now = 1'b1;
               end else begin
                  pos_in   = '0;
                  match_in = 1'b1;
                  if (evt_head.kind == EV_LIST_END) begin
                     any_in = 1'b0;
                     finish = 1'b1;
                  end
               end
            end
         end
         B_SEP: begin
            if (go) begin
               emit      = 1'b1;
               emit_byte = sep_at_cnt;
               if (SEP_LEN_W'(cnt_ff) + 1'b1 == cfg.sep_len) begin
                  cnt_in   = '0;
                  state_in = (pos_ff == '0) ? B_TAIL : B_KEY;
               end else begin
                  cnt_in = cnt_ff + 1'b1;
               end
            end
         end
         B_KEY: begin
            if (go) begin
               emit      = 1'b1;
               emit_byte = key_at_cnt;
               if (POS_W'(cnt_ff) + 1'b1 == pos_ff) begin
                  state_in = B_TAIL;
               end else begin
                  cnt_in = cnt_ff + 1'b1;
               end
            end
         end
         B_TAIL: begin
            if (go) begin
               state_in = B_IDLE;
               unique case (cur_ff.kind)
                  EV_BYTE: begin
                     emit = 1'b1;
                  end
                  EV_FIELD_END: begin
                     pos_in   = '0;
                     match_in = 1'b1;
                  end
                  EV_LIST_END: begin
                     pos_in   = '0;
                     match_in = 1'b1;
                     any_in   = 1'b0;
                     finish   = 1'b1;
                  end
                  default: begin
                     state_in = B_IDLE;
                  end
               endcase
            end
         end
         default: begin
            state_in = B_IDLE;
         end
      endcase

      if (open_now) begin
         match_in = 1'b0;
         any_in   = 1'b1;
         cnt_in   = '0;
         state_in = open_state;
      end
   end

   // words of a closing step are staged one deep so the final one can carry last
   always_comb begin
      out_push        = 1'b0;
      out_data        = '{data: staged_ff, valid: 1'b1, last: 1'b0};
      staged_in       = staged_ff;
      staged_valid_in = staged_valid_ff;
      if (finish) begin
         out_push        = 1'b1;
         out_data        = '{data: staged_valid_ff ? staged_ff : BYTE_NUL,
                             valid: staged_valid_ff, last: 1'b1};
         staged_valid_in = 1'b0;
      end else if (emit) begin
         if (ev.step_last) begin
            out_push        = staged_valid_ff;
            staged_in       = emit_byte;
            staged_valid_in = 1'b1;
         end else begin
            out_push      = 1'b1;
            out_data.data = emit_byte;
         end
      end
   end

   always_ff @(posedge clock) begin
      cur_ff    <= cur_in;
      staged_ff <= staged_in;
      if (reset) begin
         state_ff        <= B_IDLE;
         pos_ff          <= '0;
         cnt_ff          <= '0;
         match_ff        <= 1'b1;
         any_ff          <= 1'b0;
         staged_valid_ff <= 1'b0;
      end else begin
         state_ff        <= state_in;
         pos_ff          <= pos_in;
         cnt_ff          <= cnt_in;
         match_ff        <= match_in;
         any_ff          <= any_in;
         staged_valid_ff <= staged_valid_in;
      end
   end

endmodule

/* rtl/core/delimited_field_remover_top.sv */
// Delimited field remover.
// Input queue (push/full): one list byte per word with req_in_valid and req_in_last;
// a word with valid low and last high closes an empty list.
// Result queue (empty/pop): filtered bytes; a bare word (valid low, byte zero) with
// rsp_out_last high is given when a closing word produces no byte.
// CSR port: registers 0-3 key words, 4 key length, 5 separator bytes, 6 separator
// length; write only between lists or while the block is drained.
// Flow: the front scanner takes one input word at a time and keeps full high while it
// scans the byte, lets go held delimiter bytes and, in the closing word, flushes its
// window and sends the list end; a field that held a key prefix is replayed by the back
// sequencer as separator bytes and held key bytes. Results leave at up to one word per
// cycle while the result queue is popped. An accepted byte passes the scanner window,
// the event queue, the back sequencer and the result queue to the ports; in the closing
// word of a list the final result waits for the list end.
// Reset clears both queues, the scanner window and the field state; the registers
// return to an empty key and a single comma. When pop is held low the result queue
// fills, the back sequencer stops, then the event queue, then full rises.
module delimited_field_remover_top #(
   parameter int EVT_DEPTH = 4,
   parameter int OUT_DEPTH = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   output logic        full,
   input  logic [7:0]  req_in_byte,
   input  logic        req_in_valid,
   input  logic        req_in_last,
   output logic        empty,
   input  logic        pop,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_out_valid,
   output logic        rsp_out_last,
   input  logic        csr_wr_en,
   input  logic [2:0]  csr_index,
   input  logic [63:0] csr_wdata
);

   import dfr_pkg::*;

   logic [KEY_WORDS-1:0][WORD_W-1:0] key_word_ff;
   logic [POS_W-1:0]                 key_length_ff;
   logic [SEP_MAX*8-1:0]             sep_bytes_ff;
   logic [SEP_LEN_W-1:0]             sep_length_ff;

   cfg_type      cfg;
   event_type    evt_wdata, evt_rdata;
   rsp_item_type out_wdata, out_rdata;
   logic         evt_push, evt_full, evt_pop, evt_empty;
   logic         out_push, out_full;

   always_ff @(posedge clock) begin
      if (reset) begin
         key_word_ff   <= '0;
         key_length_ff <= '0;
         sep_bytes_ff  <= {{(SEP_MAX*8-8){1'b0}}, SEP_DEFAULT};
         sep_length_ff <= SEP_LEN_W'(1);
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_KEY_WORD_0: key_word_ff[0] <= csr_wdata;
            CSR_KEY_WORD_1: key_word_ff[1] <= csr_wdata;
            CSR_KEY_WORD_2: key_word_ff[2] <= csr_wdata;
            CSR_KEY_WORD_3: key_word_ff[3] <= csr_wdata;
            CSR_KEY_LENGTH: key_length_ff  <= csr_wdata[POS_W-1:0];
            CSR_SEP_BYTES:  sep_bytes_ff   <= csr_wdata[SEP_MAX*8-1:0];
            CSR_SEP_LENGTH: sep_length_ff  <= csr_wdata[SEP_LEN_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      cfg.key     = key_word_ff;
      cfg.key_len = (key_length_ff > POS_W'(KEY_MAX)) ? POS_W'(KEY_MAX) : key_length_ff;
      if (sep_length_ff == '0) begin
         cfg.sep     = {{(SEP_MAX*8-8){1'b0}}, SEP_DEFAULT};
         cfg.sep_len = SEP_LEN_W'(1);
      end else begin
         cfg.sep     = sep_bytes_ff;
         cfg.sep_len = (sep_length_ff > SEP_LEN_W'(SEP_MAX)) ? SEP_LEN_W'(SEP_MAX)
                                                             : sep_length_ff;
      end
   end

   dfr_front u_front (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .in_byte  (req_in_byte),
      .in_valid (req_in_valid),
      .in_last  (req_in_last),
      .full     (full),
      .cfg      (cfg),
      .evt_push (evt_push),
      .evt_data (evt_wdata),
      .evt_full (evt_full)
   );

   dfr_fifo #(
      .WIDTH ($bits(event_type)),
      .DEPTH (EVT_DEPTH)
   ) u_evt_fifo (
      .clock (clock),
      .reset (reset),
      .push  (evt_push),
      .wdata (evt_wdata),
      .full  (evt_full),
      .pop   (evt_pop),
      .rdata (evt_rdata),
      .empty (evt_empty)
   );

   dfr_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .evt_empty (evt_empty),
      .evt_head  (evt_rdata),
      .evt_pop   (evt_pop),
      .out_full  (out_full),
      .out_push  (out_push),
      .out_data  (out_wdata)
   );

   dfr_fifo #(
      .WIDTH ($bits(rsp_item_type)),
      .DEPTH (OUT_DEPTH)
   ) u_out_fifo (
      .clock (clock),
      .reset (reset),
      .push  (out_push),
      .wdata (out_wdata),
      .full  (out_full),
      .pop   (pop),
      .rdata (out_rdata),
      .empty (empty)
   );

   assign rsp_out_byte  = out_rdata.data;
   assign rsp_out_valid = out_rdata.valid;
   assign rsp_out_last  = out_rdata.last;

endmodule

/* rtl/core/dfr_checker.sv */
`include "delimited_field_remover_top_defines.svh"

module dfr_checker (
   input logic       clock,
   input logic       reset,
   input logic       full,
   input logic       empty,
   input logic       pop,
   input logic [7:0] rsp_out_byte,
   input logic       rsp_out_valid,
   input logic       rsp_out_last
);

   `DFR_ASSERT_ALWAYS(a_reset_drains, clock, reset, empty && !full, "reset left a word queued or input blocked")

   `DFR_ASSERT_SAME(a_bare_word, clock, reset, !empty && !rsp_out_valid, (rsp_out_byte == 8'h00) && rsp_out_last, "bare word without last or with nonzero byte")

   `DFR_ASSERT_NEXT(a_word_stays, clock, reset, !empty && !pop, !empty, "waiting word dropped")

   `DFR_ASSERT_NEXT(a_word_holds, clock, reset, !empty && !pop, $stable(rsp_out_byte) && $stable(rsp_out_valid) && $stable(rsp_out_last), "waiting word changed")

endmodule

bind delimited_field_remover_top dfr_checker u_dfr_checker (.*);
